### sv/csls_pkg.sv
// ----------------------------------------------------------------------------
// csls_pkg
// Shared types, token codes and lookup functions for the C subset scanner.
// ----------------------------------------------------------------------------
package csls_pkg;

  localparam int CSLS_MAX_TEXT = 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int NUM_KEYWORDS  = 17;

  localparam logic [6:0] CODE_END      = 7'd0;
  localparam logic [6:0] CODE_IDENT    = 7'd100;
  localparam logic [6:0] CODE_NUMBER   = 7'd111;
  localparam logic [6:0] CODE_LE       = 7'd48;
  localparam logic [6:0] CODE_LT       = 7'd46;
  localparam logic [6:0] CODE_GE       = 7'd50;
  localparam logic [6:0] CODE_GT       = 7'd49;
  localparam logic [6:0] CODE_QUESTION = 7'd51;
  localparam logic [6:0] CODE_INC      = 7'd53;
  localparam logic [6:0] CODE_PLUS     = 7'd40;
  localparam logic [6:0] CODE_DEC      = 7'd54;
  localparam logic [6:0] CODE_MINUS    = 7'd41;
  localparam logic [6:0] CODE_STAR     = 7'd42;
  localparam logic [6:0] CODE_SLASH    = 7'd43;
  localparam logic [6:0] CODE_COLON    = 7'd44;
  localparam logic [6:0] CODE_DOT      = 7'd45;
  localparam logic [6:0] CODE_EQEQ     = 7'd52;
  localparam logic [6:0] CODE_ASSIGN   = 7'd25;
  localparam logic [6:0] CODE_NE       = 7'd47;
  localparam logic [6:0] CODE_BANG     = 7'd31;
  localparam logic [6:0] CODE_LPAREN   = 7'd27;
  localparam logic [6:0] CODE_RPAREN   = 7'd28;
  localparam logic [6:0] CODE_LBRACE   = 7'd29;
  localparam logic [6:0] CODE_RBRACE   = 7'd30;
  localparam logic [6:0] CODE_LBRACKET = 7'd32;
  localparam logic [6:0] CODE_RBRACKET = 7'd33;
  localparam logic [6:0] CODE_SEMI     = 7'd26;
  localparam logic [6:0] CODE_PERCENT  = 7'd34;
  localparam logic [6:0] CODE_AMP      = 7'd35;
  localparam logic [6:0] CODE_HASH     = 7'd37;
  localparam logic [6:0] CODE_COMMA    = 7'd38;
  localparam logic [6:0] CODE_QUOTE    = 7'd39;

  typedef enum logic [8:0] {
    K_IDLE   = 9'b000000001,
    K_IDENT  = 9'b000000010,
    K_NUMBER = 9'b000000100,
    K_LT     = 9'b000001000,
    K_GT     = 9'b000010000,
    K_PLUS   = 9'b000100000,
    K_MINUS  = 9'b001000000,
    K_EQ     = 9'b010000000,
    K_BANG   = 9'b100000000
  } kind_t;

  typedef struct packed {
    logic [6:0]  code;
    logic [30:0] value;
    logic [63:0] text;
    logic [3:0]  len;
    logic        trunc;
    logic        ovf;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     first;
    token_t     second;
  } push_t;

  // strings reversed so the first character lands in byte 0
  function automatic logic [63:0] keyword_text(input logic [4:0] idx);
    case (idx)
      5'd0:    return 64'("edulcni");
      5'd1:    return 64'("fi");
      5'd2:    return 64'("rof");
      5'd3:    return 64'("elihw");
      5'd4:    return 64'("od");
      5'd5:    return 64'("kaerb");
      5'd6:    return 64'("nruter");
      5'd7:    return 64'("esle");
      5'd8:    return 64'("hctiws");
      5'd9:    return 64'("esac");
      5'd10:   return 64'("diov");
      5'd11:   return 64'("tni");
      5'd12:   return 64'("elbuod");
      5'd13:   return 64'("gnol");
      5'd14:   return 64'("rahc");
      5'd15:   return 64'("tcurts");
      5'd16:   return 64'("tixe");
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] single_code(input logic [7:0] c);
    case (c)
      "?":     return CODE_QUESTION;
      "*":     return CODE_STAR;
      "/":     return CODE_SLASH;
      ":":     return CODE_COLON;
      ".":     return CODE_DOT;
      "(":     return CODE_LPAREN;
      ")":     return CODE_RPAREN;
      "{":     return CODE_LBRACE;
      "}":     return CODE_RBRACE;
      "[":     return CODE_LBRACKET;
      "]":     return CODE_RBRACKET;
      ";":     return CODE_SEMI;
      "%":     return CODE_PERCENT;
      "&":     return CODE_AMP;
      "#":     return CODE_HASH;
      ",":     return CODE_COMMA;
      "\"":    return CODE_QUOTE;
      default: return CODE_END;
    endcase
  endfunction

endpackage

### sv/csls_core.sv
// ----------------------------------------------------------------------------
// csls_core
// Scanner state and per-byte token logic; yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module csls_core import csls_pkg::*; #(
  parameter int MAX_TEXT = CSLS_MAX_TEXT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_in,
  output push_t      push
);

  localparam int CW = $clog2(MAX_TEXT + 2);
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  kind_t          kind, kind_next;
  logic [63:0]    text_buffer, text_buffer_next;
  logic [CW-1:0]  char_count, char_count_next;
  logic [30:0]    number_accumulator, number_accumulator_next;
  logic           overflow_seen, overflow_seen_next;

  logic        is_letter, is_digit, is_space;
  logic        trunc;
  logic [6:0]  kw_code;
  logic [34:0] acc_times_ten;
  logic        acc_sat;
  logic [7:0]  op_first, op_second;
  logic [6:0]  pair_code, lone_code, lone_single;
  token_t      tok_a, tok_b, r0;
  logic        a_v, b_v, start;

  assign is_letter = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
  assign is_digit  = char_in >= "0" && char_in <= "9";
  assign is_space  = char_in == " " || char_in == "\t" || char_in == "\n";
  assign trunc     = char_count > CW'(MAX_TEXT);
  assign lone_single = single_code(char_in);

  assign acc_times_ten = ({4'b0, number_accumulator} << 3) + ({4'b0, number_accumulator} << 1)
                       + {31'b0, char_in[3:0]};
  assign acc_sat = acc_times_ten > {4'b0, NUM_MAX};

  always_comb begin
    kw_code = CODE_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (!trunc && text_buffer == keyword_text(5'(k))) kw_code = 7'(k + 1);
    end
  end

  always_comb begin
    op_first  = 8'h00;
    op_second = 8'h00;
    pair_code = CODE_END;
    lone_code = CODE_END;
    case (kind)
      K_LT:    begin op_first = "<"; op_second = "="; pair_code = CODE_LE;   lone_code = CODE_LT;     end
      K_GT:    begin op_first = ">"; op_second = "="; pair_code = CODE_GE;   lone_code = CODE_GT;     end
      K_PLUS:  begin op_first = "+"; op_second = "+"; pair_code = CODE_INC;  lone_code = CODE_PLUS;   end
      K_MINUS: begin op_first = "-"; op_second = "-"; pair_code = CODE_DEC;  lone_code = CODE_MINUS;  end
      K_EQ:    begin op_first = "="; op_second = "="; pair_code = CODE_EQEQ; lone_code = CODE_ASSIGN; end
      K_BANG:  begin op_first = "!"; op_second = "="; pair_code = CODE_NE;   lone_code = CODE_BANG;   end
      default: begin end
    endcase
  end

  always_comb begin
    kind_next               = kind;
    text_buffer_next        = text_buffer;
    char_count_next         = char_count;
    number_accumulator_next = number_accumulator;
    overflow_seen_next      = overflow_seen;
    tok_a = '0;
    tok_b = '0;
    a_v   = 1'b0;
    b_v   = 1'b0;
    start = 1'b0;

    case (kind)
      K_IDENT: begin
        if (is_letter || is_digit) begin
          for (int i = 0; i < 8; i++) begin
            if (i < MAX_TEXT && char_count == CW'(i)) text_buffer_next[8*i +: 8] = char_in;
          end
          if (!trunc) char_count_next = char_count + CW'(1);
        end else begin
          a_v        = 1'b1;
          tok_a.code = kw_code;
          tok_a.text = text_buffer;
          tok_a.len  = trunc ? 4'(MAX_TEXT) : 4'(char_count);
          tok_a.trunc = trunc;
          start      = 1'b1;
        end
      end
      K_NUMBER: begin
        if (is_digit) begin
          number_accumulator_next = acc_sat ? NUM_MAX : acc_times_ten[30:0];
          overflow_seen_next      = overflow_seen | acc_sat;
        end else begin
          a_v         = 1'b1;
          tok_a.code  = CODE_NUMBER;
          tok_a.value = number_accumulator;
          tok_a.ovf   = overflow_seen;
          start       = 1'b1;
        end
      end
      K_LT, K_GT, K_PLUS, K_MINUS, K_EQ, K_BANG: begin
        a_v = 1'b1;
        if (char_in == op_second) begin
          tok_a.code = pair_code;
          tok_a.text = {48'b0, char_in, op_first};
          tok_a.len  = 4'd2;
          kind_next               = K_IDLE;
          text_buffer_next        = '0;
          char_count_next         = '0;
          number_accumulator_next = '0;
          overflow_seen_next      = 1'b0;
        end else begin
          tok_a.code = lone_code;
          tok_a.text = {56'b0, op_first};
          tok_a.len  = 4'd1;
          start      = 1'b1;
        end
      end
      default: start = 1'b1;
    endcase

    if (start) begin
      kind_next               = K_IDLE;
      text_buffer_next        = '0;
      char_count_next         = '0;
      number_accumulator_next = '0;
      overflow_seen_next      = 1'b0;
      if (is_space) begin
      end else if (is_letter) begin
        kind_next        = K_IDENT;
        text_buffer_next = {56'b0, char_in};
        char_count_next  = CW'(1);
      end else if (is_digit) begin
        kind_next               = K_NUMBER;
        number_accumulator_next = {27'b0, char_in[3:0]};
      end else begin
        case (char_in)
          "<":     kind_next = K_LT;
          ">":     kind_next = K_GT;
          "+":     kind_next = K_PLUS;
          "-":     kind_next = K_MINUS;
          "=":     kind_next = K_EQ;
          "!":     kind_next = K_BANG;
          8'h00:   b_v = 1'b1;
          default: begin
            if (lone_single != CODE_END) begin
              b_v        = 1'b1;
              tok_b.code = lone_single;
              tok_b.text = {56'b0, char_in};
              tok_b.len  = 4'd1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    r0      = a_v ? tok_a : tok_b;
    r0.last = !(a_v && b_v);
    push.first       = r0;
    push.second      = tok_b;
    push.second.last = 1'b1;
    push.n = take ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind               <= K_IDLE;
      text_buffer        <= '0;
      char_count         <= '0;
      number_accumulator <= '0;
      overflow_seen      <= 1'b0;
    end else if (take) begin
      kind               <= kind_next;
      text_buffer        <= text_buffer_next;
      char_count         <= char_count_next;
      number_accumulator <= number_accumulator_next;
      overflow_seen      <= overflow_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && char_in == 8'h00 |=> kind == K_IDLE && char_count == '0)
    else $error("end of text left scanner state");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> !push.first.last && push.second.last)
    else $error("last flag misplaced on two-token byte");

  a_ident_count: assert property (@(posedge clk) disable iff (rst)
    kind == K_IDENT |-> char_count != '0)
    else $error("identifier pending with no characters");
`endif

endmodule

### sv/csls_queue.sv
// ----------------------------------------------------------------------------
// csls_queue
// Small token queue: takes up to two tokens per cycle while room is high, hands out one as out_ready allows.
// ----------------------------------------------------------------------------
module csls_queue import csls_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  output logic   room,
  output logic   out_valid,
  input  logic   out_ready,
  output token_t head_tok
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  token_t          slots [DEPTH];
  logic [PW-1:0]   head, tail;
  logic [CNTW-1:0] count;
  logic            pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign room      = count <= CNTW'(DEPTH - 2);
  assign tail      = head + count[PW-1:0];
  assign head_tok  = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + PW'(1);
      count <= count + CNTW'(push.n) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) slots[tail] <= push.first;
    if (push.n == 2'd2) slots[tail + PW'(1)] <= push.second;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count <= CNTW'(DEPTH - 2))
    else $error("push without room for two tokens");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && head == $past(head))
    else $error("queued token lost while stalled");
`endif

endmodule

### sv/c_subset_lexical_scanner.sv
// Throughput: one byte per cycle while in_ready is high; each token is written
// into the output queue by the byte that ends it. A byte that ends a token and
// starts a single-character one yields two tokens, drained one per cycle by the
// queue when out_ready is high. in_ready is high while it has room for two.
// Reset: synchronous, clears scanner state and empties the output queue.
// ----------------------------------------------------------------------------
// c_subset_lexical_scanner
// Byte-stream tokenizer for a small C subset with keyword match.
// ----------------------------------------------------------------------------
module c_subset_lexical_scanner import csls_pkg::*; #(
  parameter int MAX_TEXT = CSLS_MAX_TEXT,
  parameter int DEPTH    = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  token_code,
  output logic [30:0] number_value,
  output logic [63:0] token_text,
  output logic [3:0]  text_length,
  output logic        text_truncated,
  output logic        number_overflow,
  output logic        last_of_run
);

  push_t  push;
  token_t head_tok;
  logic   take;

  assign take = in_valid && in_ready;

  csls_core #(.MAX_TEXT(MAX_TEXT)) u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .char_in (char_in),
    .push    (push)
  );

  csls_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_tok  (head_tok)
  );

  assign token_code      = head_tok.code;
  assign number_value    = head_tok.value;
  assign token_text      = head_tok.text;
  assign text_length     = head_tok.len;
  assign text_truncated  = head_tok.trunc;
  assign number_overflow = head_tok.ovf;
  assign last_of_run     = head_tok.last;

endmodule
